/* design/assert_macros.svh */
// assertion macros used by the top file of the base64 encoder
// no dependencies; each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be true at a clock edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* design/b64e_pkg.sv */
// shared types, constants and the alphabet function of the base64 encoder
// no dependencies
package b64e_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // number of characters that carry real bits in a group
  localparam logic [2:0] REAL_ONE_BYTE   = 3'd2;
  localparam logic [2:0] REAL_TWO_BYTES  = 3'd3;
  localparam logic [2:0] REAL_FULL_GROUP = 3'd4;

  // one group of three bytes handed from front to back
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [2:0] real_cnt;
    logic       fin;
  } grp_t;

  // queue status seen by the front and the top
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // sextet to base64 ascii
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      return w + 8'd65;
    end else if (v < 6'd52) begin
      return w + 8'd71;
    end else if (v < 6'd62) begin
      return w - 8'd4;
    end else if (v == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

endpackage

/* design/b64e_front.sv */
// front end: accepts input words, holds partial groups, pushes full and final partial groups
// depends on b64e_pkg
module b64e_front import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_final_byte,
  input  q_stat_t    q_stat,
  output logic       push,
  output grp_t       push_grp
);

  logic [1:0] pos_r, pos_nxt;
  logic [7:0] held0_r, held0_nxt;
  logic [7:0] held1_r, held1_nxt;
  logic       acc;

  assign in_ready = !q_stat.full;
  assign acc      = in_valid && in_ready;

  // classify the word against the group position
  always_comb begin
    pos_nxt   = pos_r;
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    push      = 1'b0;
    push_grp  = '{b0: held0_r, b1: held1_r, b2: in_data_byte,
                  real_cnt: REAL_FULL_GROUP, fin: in_final_byte};
    if (acc) begin
      if (pos_r >= 2'd2) begin
        push      = 1'b1;
        pos_nxt   = 2'd0;
        held0_nxt = 8'd0;
        held1_nxt = 8'd0;
      end else if (in_final_byte) begin
        push      = 1'b1;
        pos_nxt   = 2'd0;
        held0_nxt = 8'd0;
        held1_nxt = 8'd0;
        if (pos_r == 2'd0) begin
          push_grp = '{b0: in_data_byte, b1: 8'd0, b2: 8'd0,
                       real_cnt: REAL_ONE_BYTE, fin: 1'b1};
        end else begin
          push_grp = '{b0: held0_r, b1: in_data_byte, b2: 8'd0,
                       real_cnt: REAL_TWO_BYTES, fin: 1'b1};
        end
      end else begin
        pos_nxt = pos_r + 2'd1;
        if (pos_r == 2'd0) begin
          held0_nxt = in_data_byte;
        end else begin
          held1_nxt = in_data_byte;
        end
      end
    end
  end

  // group state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 2'd0;
      held0_r <= 8'd0;
      held1_r <= 8'd0;
    end else begin
      pos_r   <= pos_nxt;
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
    end
  end

endmodule

/* design/b64e_queue.sv */
// short group queue between front and back, show-ahead read
// depends on b64e_pkg
module b64e_queue import b64e_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  grp_t    push_grp,
  input  logic    pop,
  output grp_t    head_grp,
  output q_stat_t q_stat
);

  grp_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign q_stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_grp     = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_grp;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* design/b64e_back.sv */
// back end: splits a group into four characters, one per cycle while out_ready allows, into the output register
// depends on b64e_pkg
module b64e_back import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  grp_t       head_grp,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_run_end,
  output logic       out_stream_end
);

  grp_t       grp_r;
  logic       grp_vld_r, grp_vld_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       out_vld_r;
  logic [7:0] char_r;
  logic       run_end_r;
  logic       stream_end_r;
  logic       load;
  logic       last_char;
  logic [5:0] sextet;
  logic [7:0] char_nxt;

  assign load      = grp_vld_r && (!out_vld_r || out_ready);
  assign last_char = (idx_r == 2'd3);
  assign pop       = !q_empty && (!grp_vld_r || (load && last_char));

  // sextet select for the current character
  always_comb begin
    case (idx_r)
      2'd0:    sextet = grp_r.b0[7:2];
      2'd1:    sextet = {grp_r.b0[1:0], grp_r.b1[7:4]};
      2'd2:    sextet = {grp_r.b1[3:0], grp_r.b2[7:6]};
      2'd3:    sextet = grp_r.b2[5:0];
      default: sextet = 6'd0;
    endcase
    char_nxt = ({1'b0, idx_r} < grp_r.real_cnt) ? b64_char(sextet) : PAD_CHAR;
  end

  // group slot sequencing
  always_comb begin
    grp_vld_nxt = grp_vld_r;
    idx_nxt     = idx_r;
    if (load) begin
      idx_nxt = idx_r + 2'd1;
      if (last_char) begin
        grp_vld_nxt = 1'b0;
      end
    end
    if (pop) begin
      grp_vld_nxt = 1'b1;
      idx_nxt     = 2'd0;
    end
  end

  // group slot and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_vld_r <= 1'b0;
      idx_r     <= 2'd0;
      out_vld_r <= 1'b0;
    end else begin
      grp_vld_r <= grp_vld_nxt;
      idx_r     <= idx_nxt;
      if (load) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      grp_r <= head_grp;
    end
    if (load) begin
      char_r       <= char_nxt;
      run_end_r    <= last_char;
      stream_end_r <= last_char && grp_r.fin;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_char       = char_r;
  assign out_run_end    = run_end_r;
  assign out_stream_end = stream_end_r;

endmodule

/* design/base64_stream_encoder.sv */
// base64 stream encoder top: front end, group queue, character back end.
// path: a closing word goes through the queue, the group slot and the output register.
// throughput: one word per cycle in while the queue has room, one character per cycle out
//   while out_ready allows; the back end's single output register emits four per group.
// reset: synchronous active-low rst_n clears group position, held bytes, queue and output.
`include "assert_macros.svh"

module base64_stream_encoder import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_final_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_run_end,
  output logic       out_stream_end
);

  q_stat_t q_stat;
  logic    push;
  grp_t    push_grp;
  logic    pop;
  grp_t    head_grp;

  // word intake and grouping
  b64e_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .q_stat        (q_stat),
    .push          (push),
    .push_grp      (push_grp)
  );

  // group queue
  b64e_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .head_grp (head_grp),
    .q_stat   (q_stat)
  );

  // character generation
  b64e_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_stat.empty),
    .head_grp       (head_grp),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .out_run_end    (out_run_end),
    .out_stream_end (out_stream_end)
  );

  // checks
  `ASSERT_CLK(a_stream_end_on_run_end, out_valid && out_stream_end |-> out_run_end, "stream end without run end")
  `ASSERT_CLK(a_pad_continues, out_valid && out_ready && out_char == PAD_CHAR && !out_run_end |=> out_valid && out_char == PAD_CHAR, "pad not followed by pad")
  `ASSERT_NEVER(a_queue_stat, q_stat.full && q_stat.empty, "queue full and empty at once")
  `ASSERT_CLK(a_push_room, push |-> !q_stat.full, "push into full queue")

endmodule
